@@ rtl/core/kitl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kitl_pkg
// types, constants and codes shared by the keyed index table
// ----------------------------------------------------------------------------
package kitl_pkg;

    localparam int DEF_SLOTS    = 256;
    localparam int DEF_KEY_BITS = 64;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_KEY    = 3'd1,
        KIND_PATH   = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_UPDATE = 3'd4,
        KIND_CLEAR  = 3'd5,
        KIND_NOP6   = 3'd6,
        KIND_NOP7   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ACTIVE  = 2'd0,
        CFG_QUEUED  = 2'd1,
        CFG_STAGING = 2'd2,
        CFG_ONLINE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_OUT
    } state_t;

    // record payload carried with an item and held in every cell
    typedef struct packed {
        logic [63:0] path_hash;
        logic [47:0] offset;
        logic [31:0] added;
        logic [31:0] expire;
        logic [7:0]  status;
        logic [7:0]  prio;
        logic [7:0]  queue;
        logic [31:0] last_used;
    } rec_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic       write_all;
        logic       write_upd;
        logic       touch;
        logic       set_key;
        logic       clear_valid;
        logic       clear_all;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/keyed_index_table_lru.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_index_table_lru
// keyed slot table with lru replacement, built as a rotating row of cells
// ----------------------------------------------------------------------------
// channel   dir  handshake          content
// s_axis    in   tvalid/tready      request item
// m_axis    out  tvalid/tready      result item
// cfg       in   cfg_we             register writes, no read-back
//
// after an item is accepted, the cell row rotates once through all SLOTS
// positions while slot 0's head is compared, then the apply and load states
// follow before the result is valid.
// reset is synchronous; the table is empty right after reset, no clearing pass.
// a result waits in the output register; the next item is taken the cycle after
// it leaves, so no new item is taken before the last result has left.
module keyed_index_table_lru #(
    parameter int SLOTS    = kitl_pkg::DEF_SLOTS,
    parameter int KEY_BITS = kitl_pkg::DEF_KEY_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // kind[2:0] key[66:3] path_hash[130:67] offset_in[178:131] added_time[210:179]
    // expire_time[242:211] status_in[250:243] priority_in[258:251]
    // queue_in[266:259] now_ms[298:267] want_live[299], zero fill to 304
    input  wire logic [303:0]              s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // found[0] offset_out[48:1] occupancy[57:49] evicted[58]
    // evictions_total[90:59], zero fill to 96
    output logic [95:0]                    m_tdata,
    input  wire logic                      cfg_we,
    input  wire logic [kitl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kitl_pkg::CFG_W-1:0]     cfg_data
);
    import kitl_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [8:0] active_reg;
    logic [7:0] live_q_reg, live_s_reg, live_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 9'd256;
            live_q_reg <= 8'd0;
            live_s_reg <= 8'd1;
            live_o_reg <= 8'd2;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE:  active_reg <= cfg_data;
                CFG_QUEUED:  live_q_reg <= cfg_data[7:0];
                CFG_STAGING: live_s_reg <= cfg_data[7:0];
                CFG_ONLINE:  live_o_reg <= cfg_data[7:0];
            endcase
        end
    end

    // item fields
    kind_t               kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    rec_t                rec_reg;
    logic                live_reg;

    state_t  state_reg, state_next;
    logic [CW-1:0] step_reg;
    logic [CW-1:0] lim;

    assign lim = (int'(active_reg) > SLOTS) ? CW'(SLOTS) : CW'(active_reg);

    // scan results
    logic          key_hit_reg, free_hit_reg, vic_hit_reg, path_hit_reg;
    logic [IW-1:0] key_idx_reg, free_idx_reg, vic_idx_reg;
    logic [31:0]   vic_lu_reg, best_add_reg;
    logic [47:0]   best_off_reg, key_off_reg;
    logic [CW-1:0] used_reg;
    logic [31:0]   evc_reg;

    logic [95:0]   out_reg;
    logic          out_v_reg;

    // cell row
    logic                valid_w [SLOTS];
    logic [KEY_BITS-1:0] keys_w  [SLOTS];
    rec_t                recs_w  [SLOTS];
    logic [SLOTS-1:0]    sel;
    cell_ctl_t           ctl;
    logic                shift;
    logic [IW-1:0]       tgt;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            localparam int P = (g + 1) % SLOTS;
            kitl_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift      (shift),
                .sel        (sel[g]),
                .ctl        (ctl),
                .key_in     (key_reg),
                .rec_in     (rec_reg),
                .prev_valid (valid_w[P]),
                .prev_key   (keys_w[P]),
                .prev_rec   (recs_w[P]),
                .valid      (valid_w[g]),
                .key        (keys_w[g]),
                .rec        (recs_w[g])
            );
            assign sel[g] = (tgt == IW'(g));
        end
    endgenerate

    // head of row holds slot step_reg during scan
    logic          in_range, head_v, key_eq, path_eq, live_ok;
    logic [IW-1:0] cur;
    rec_t          head;

    assign cur      = step_reg[IW-1:0];
    assign head     = recs_w[0];
    assign in_range = (step_reg < lim);
    assign head_v   = valid_w[0] && in_range;
    assign key_eq   = head_v && (keys_w[0] == key_reg);
    assign live_ok  = !live_reg || head.status == live_q_reg ||
                      head.status == live_s_reg || head.status == live_o_reg;
    assign path_eq  = head_v && head.path_hash == rec_reg.path_hash && live_ok;

    // apply decisions
    logic do_ins, ins_new, ins_evict;
    assign do_ins    = (lim != '0);
    assign ins_new   = !key_hit_reg && free_hit_reg;
    assign ins_evict = !key_hit_reg && !free_hit_reg;

    always_comb begin
        state_next = state_reg;
        shift      = 1'b0;
        ctl        = '0;
        tgt        = key_idx_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = !out_v_reg;
                if (s_tvalid && !out_v_reg) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                shift = 1'b1;
                if (step_reg == CW'(SLOTS - 1)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                state_next = ST_OUT;
                unique case (kind_reg)
                    KIND_INSERT: begin
                        if (do_ins) begin
                            ctl.write_all = 1'b1;
                            ctl.set_key   = !key_hit_reg;
                            tgt = key_hit_reg ? key_idx_reg :
                                  (free_hit_reg ? free_idx_reg : vic_idx_reg);
                        end
                    end
                    KIND_KEY:    ctl.touch = key_hit_reg && (key_reg != '0);
                    KIND_REMOVE: ctl.clear_valid = key_hit_reg;
                    KIND_UPDATE: ctl.write_upd = key_hit_reg;
                    KIND_CLEAR:  ctl.clear_all = 1'b1;
                    default: ;
                endcase
                if (!key_hit_reg) begin
                    ctl.touch       = 1'b0;
                    ctl.clear_valid = 1'b0;
                    ctl.write_upd   = 1'b0;
                end
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            evc_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (state_reg == ST_APPLY) begin
                unique case (kind_reg)
                    KIND_INSERT: begin
                        if (do_ins && ins_new) begin
                            used_reg <= used_reg + 1'b1;
                        end
                        if (do_ins && ins_evict) begin
                            evc_reg <= evc_reg + 32'd1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (key_hit_reg && used_reg != '0) begin
                            used_reg <= used_reg - 1'b1;
                        end
                    end
                    KIND_CLEAR: used_reg <= '0;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT) begin
                out_v_reg <= 1'b1;
            end
        end
    end

    logic is_key, is_path, fnd;
    assign is_key  = (kind_reg == KIND_KEY) && key_hit_reg && (key_reg != '0);
    assign is_path = (kind_reg == KIND_PATH) && path_hit_reg;
    assign fnd     = is_key || is_path;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid && !out_v_reg) begin
            kind_reg           <= kind_t'(s_tdata[2:0]);
            key_reg            <= s_tdata[3 +: KEY_BITS];
            rec_reg.path_hash  <= s_tdata[130:67];
            rec_reg.offset     <= s_tdata[178:131];
            rec_reg.added      <= s_tdata[210:179];
            rec_reg.expire     <= s_tdata[242:211];
            rec_reg.status     <= s_tdata[250:243];
            rec_reg.prio       <= s_tdata[258:251];
            rec_reg.queue      <= s_tdata[266:259];
            rec_reg.last_used  <= s_tdata[298:267];
            live_reg           <= s_tdata[299];
            step_reg           <= '0;
            key_hit_reg        <= 1'b0;
            free_hit_reg       <= 1'b0;
            vic_hit_reg        <= 1'b0;
            path_hit_reg       <= 1'b0;
            key_idx_reg        <= '0;
            free_idx_reg       <= '0;
            vic_idx_reg        <= '0;
            vic_lu_reg         <= '0;
            best_add_reg       <= '0;
            best_off_reg       <= '0;
            key_off_reg        <= '0;
        end
        if (state_reg == ST_SCAN) begin
            step_reg <= step_reg + 1'b1;
            if (key_eq && !key_hit_reg) begin
                key_hit_reg <= 1'b1;
                key_idx_reg <= cur;
                key_off_reg <= head.offset;
            end
            if (in_range && !valid_w[0] && !free_hit_reg) begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= cur;
            end
            if (head_v && !free_hit_reg &&
                (!vic_hit_reg || head.last_used < vic_lu_reg)) begin
                vic_hit_reg <= 1'b1;
                vic_idx_reg <= cur;
                vic_lu_reg  <= head.last_used;
            end
            if (path_eq && (!path_hit_reg || head.added >= best_add_reg)) begin
                path_hit_reg <= 1'b1;
                best_add_reg <= head.added;
                best_off_reg <= head.offset;
            end
        end
        if (state_reg == ST_OUT) begin
            out_reg <= {5'd0, evc_reg,
                        (kind_reg == KIND_INSERT) && do_ins && ins_evict,
                        9'(used_reg),
                        is_key ? key_off_reg :
                                 (is_path ? best_off_reg : 48'd0),
                        fnd};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while busy");
    a_out_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_tvalid)
        else $error("result not presented");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(SLOTS))
        else $error("occupancy overflow");
`endif

endmodule

`default_nettype wire

@@ rtl/core/kitl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kitl_cell
// one table slot; the cell shifts with its neighbors on each scan step
// ----------------------------------------------------------------------------
module kitl_cell #(
    parameter int KEY_BITS = kitl_pkg::DEF_KEY_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  shift,
    input  wire logic                  sel,
    input  wire kitl_pkg::cell_ctl_t   ctl,
    input  wire logic [KEY_BITS-1:0]   key_in,
    input  wire kitl_pkg::rec_t        rec_in,
    input  wire logic                  prev_valid,
    input  wire logic [KEY_BITS-1:0]   prev_key,
    input  wire kitl_pkg::rec_t        prev_rec,
    output logic                       valid,
    output logic [KEY_BITS-1:0]        key,
    output kitl_pkg::rec_t             rec
);
    import kitl_pkg::*;

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    rec_t                rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= prev_valid;
        end else if (ctl.clear_all) begin
            valid_reg <= 1'b0;
        end else if (sel && ctl.clear_valid) begin
            valid_reg <= 1'b0;
        end else if (sel && ctl.write_all) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg <= prev_key;
            rec_reg <= prev_rec;
        end else if (sel) begin
            if (ctl.set_key) begin
                key_reg <= key_in;
            end
            if (ctl.write_all) begin
                rec_reg <= rec_in;
            end else if (ctl.write_upd) begin
                rec_reg.status    <= rec_in.status;
                rec_reg.expire    <= rec_in.expire;
                rec_reg.last_used <= rec_in.last_used;
            end else if (ctl.touch) begin
                rec_reg.last_used <= rec_in.last_used;
            end
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign rec   = rec_reg;

endmodule

`default_nettype wire

@@ tb/keyed_index_table_lru_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_index_table_lru_tb
// drives request items through the keyed slot table and checks every result
// against an in-bench table model or, for the directed rows, a fixed expected
// result, over several register settings and several patterns of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module keyed_index_table_lru_tb;
    import kitl_pkg::*;

    localparam int NSLOT = 256;

    typedef struct {
        kind_t       kind;
        logic [63:0] key;
        logic [63:0] path_hash;
        logic [47:0] offset;
        logic [31:0] added;
        logic [31:0] expire;
        logic [7:0]  status;
        logic [7:0]  prio;
        logic [7:0]  queue;
        logic [31:0] now;
        logic        want_live;
    } req_t;

    typedef struct {
        logic        found;
        logic [47:0] offset;
        logic [8:0]  occupancy;
        logic        evicted;
        logic [31:0] evictions;
    } resp_t;

    typedef struct {
        req_t  req;
        logic  typed;
        resp_t resp;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [303:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // table model
    logic        tbl_valid [NSLOT];
    logic [63:0] tbl_key [NSLOT];
    logic [63:0] tbl_hash [NSLOT];
    logic [47:0] tbl_off [NSLOT];
    logic [31:0] tbl_added [NSLOT];
    logic [31:0] tbl_expire [NSLOT];
    logic [7:0]  tbl_status [NSLOT];
    logic [31:0] tbl_used [NSLOT];
    int          tbl_count;
    logic [31:0] tbl_evictions;
    logic [8:0]  reg_active;
    logic [7:0]  reg_live [3];

    resp_t       pending_results [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [63:0] key_pool [8];
    logic [63:0] hash_pool [4];
    logic [31:0] clock_ms = 0;

    keyed_index_table_lru u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [303:0] pack_req(req_t r);
        return {4'b0, r.want_live, r.now, r.queue, r.prio, r.status, r.expire,
                r.added, r.offset, r.path_hash, r.key, r.kind};
    endfunction

    function automatic int find_slot(logic [63:0] key, int lim);
        for (int i = 0; i < lim; i++)
            if (tbl_valid[i] && tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic resp_t apply_request(req_t r);
        resp_t o;
        int lim;
        int e;
        int victim;
        logic [31:0] oldest;
        logic [31:0] best;
        o = '{default: '0};
        lim = (reg_active > NSLOT) ? NSLOT : int'(reg_active);
        oldest = '0;
        best = '0;
        case (r.kind)
            KIND_INSERT: begin
                e = find_slot(r.key, lim);
                if (e < 0 && lim > 0) begin
                    victim = -1;
                    for (int i = 0; i < lim; i++) begin
                        if (!tbl_valid[i]) begin
                            e = i;
                            break;
                        end
                        if (victim < 0 || tbl_used[i] < oldest) begin
                            victim = i;
                            oldest = tbl_used[i];
                        end
                    end
                    if (e < 0) begin
                        e = victim;
                        tbl_evictions++;
                        o.evicted = 1'b1;
                    end else begin
                        tbl_count++;
                    end
                    tbl_key[e] = r.key;
                end
                if (e >= 0) begin
                    tbl_hash[e] = r.path_hash;
                    tbl_off[e] = r.offset;
                    tbl_added[e] = r.added;
                    tbl_expire[e] = r.expire;
                    tbl_status[e] = r.status;
                    tbl_used[e] = r.now;
                    tbl_valid[e] = 1'b1;
                end
            end
            KIND_KEY: begin
                if (r.key != 0) begin
                    e = find_slot(r.key, lim);
                    if (e >= 0) begin
                        o.found = 1'b1;
                        o.offset = tbl_off[e];
                        tbl_used[e] = r.now;
                    end
                end
            end
            KIND_PATH: begin
                for (int i = 0; i < lim; i++) begin
                    if (!tbl_valid[i] || tbl_hash[i] != r.path_hash) continue;
                    if (r.want_live && tbl_status[i] != reg_live[0] &&
                        tbl_status[i] != reg_live[1] && tbl_status[i] != reg_live[2])
                        continue;
                    if (!o.found || tbl_added[i] >= best) begin
                        o.found = 1'b1;
                        best = tbl_added[i];
                        o.offset = tbl_off[i];
                    end
                end
            end
            KIND_REMOVE: begin
                e = find_slot(r.key, lim);
                if (e >= 0) begin
                    tbl_valid[e] = 1'b0;
                    if (tbl_count > 0) tbl_count--;
                end
            end
            KIND_UPDATE: begin
                e = find_slot(r.key, lim);
                if (e >= 0) begin
                    tbl_status[e] = r.status;
                    tbl_expire[e] = r.expire;
                    tbl_used[e] = r.now;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
                tbl_count = 0;
            end
            default: ;
        endcase
        o.occupancy = tbl_count[8:0];
        o.evictions = tbl_evictions;
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", field, got, want);
        errors++;
    endtask

    // result side: check and random stalls
    always @(posedge aclk) begin
        resp_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[63:0], 0);
            end else begin
                w = pending_results.pop_front();
                if (m_tdata[0] !== w.found) report_mismatch("found", m_tdata[0], w.found);
                if (m_tdata[48:1] !== w.offset)
                    report_mismatch("offset_out", m_tdata[48:1], w.offset);
                if (m_tdata[57:49] !== w.occupancy)
                    report_mismatch("occupancy", m_tdata[57:49], w.occupancy);
                if (m_tdata[58] !== w.evicted)
                    report_mismatch("evicted", m_tdata[58], w.evicted);
                if (m_tdata[90:59] !== w.evictions)
                    report_mismatch("evictions_total", m_tdata[90:59], w.evictions);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_req(req_t r, logic typed, resp_t typed_resp);
        resp_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_req(r);
        do @(posedge aclk); while (!s_tready);
        p = apply_request(r);
        pending_results.push_back(typed ? typed_resp : p);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE:  reg_active = val;
            CFG_QUEUED:  reg_live[0] = val[7:0];
            CFG_STAGING: reg_live[1] = val[7:0];
            default:     reg_live[2] = val[7:0];
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic req_t random_req(bit fresh);
        req_t r;
        int k;
        k = $urandom_range(99);
        if (fresh) r.kind = (k < 90) ? KIND_INSERT : KIND_KEY;
        else if (k < 40) r.kind = KIND_INSERT;
        else if (k < 60) r.kind = KIND_KEY;
        else if (k < 75) r.kind = KIND_PATH;
        else if (k < 85) r.kind = KIND_REMOVE;
        else if (k < 95) r.kind = KIND_UPDATE;
        else if (k < 97) r.kind = KIND_CLEAR;
        else r.kind = kind_t'($urandom_range(6, 7));
        r.key = (fresh || $urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(7)];
        r.path_hash = ($urandom_range(9) == 0) ? rand64() : hash_pool[$urandom_range(3)];
        r.offset = 48'(rand64());
        r.added = ($urandom_range(1)) ? $urandom() : $urandom_range(3);
        r.expire = $urandom();
        r.status = ($urandom_range(1)) ? reg_live[$urandom_range(2)] : $urandom_range(255);
        r.prio = $urandom_range(255);
        r.queue = $urandom_range(255);
        if ($urandom_range(9) == 0) begin
            r.now = $urandom();
        end else begin
            clock_ms = clock_ms + $urandom_range(2);
            r.now = clock_ms;
        end
        r.want_live = $urandom_range(1);
        return r;
    endfunction

    function automatic req_t mk(kind_t kd, logic [63:0] key, logic [63:0] h, logic [47:0] off,
                                logic [31:0] added, logic [7:0] st, logic wl);
        req_t r;
        r = '{kind: kd, key: key, path_hash: h, offset: off, added: added,
              expire: {32{added[0]}}, status: st, prio: {8{wl}}, queue: ~{8{wl}},
              now: added, want_live: wl};
        return r;
    endfunction

    function automatic resp_t rs(logic f, logic [47:0] off, logic [8:0] occ);
        resp_t o;
        o = '{found: f, offset: off, occupancy: occ, evicted: 1'b0, evictions: '0};
        return o;
    endfunction

    task automatic run_phase(int n, int idle, int stall, bit fresh);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) send_req(random_req(fresh), 1'b0, rs(0, 0, 0));
        drain();
    endtask

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        row_t rows [$];
        logic [63:0] ones;
        ones = '1;
        for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;
        tbl_evictions = '0;
        reg_active = 9'd256;
        reg_live[0] = 8'd0;
        reg_live[1] = 8'd1;
        reg_live[2] = 8'd2;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom_range(15);
        for (int i = 0; i < 4; i++) hash_pool[i] = rand64();

        rows.push_back('{mk(KIND_INSERT, 64'd1, ones, '1, '1, 8'hff, 1'b1), 1, rs(0, 0, 1)});
        rows.push_back('{mk(KIND_KEY, 64'd1, 0, 0, 32'd5, 0, 0), 1, rs(1, '1, 1)});
        rows.push_back('{mk(KIND_KEY, 64'd0, 0, 0, 32'd6, 0, 0), 1, rs(0, 0, 1)});
        rows.push_back('{mk(KIND_INSERT, 64'd0, 0, 0, 0, 0, 0), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_KEY, 64'd0, 0, 0, 32'd7, 0, 0), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_KEY, ones, 0, 0, 32'd8, 0, 0), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_INSERT, ones, ones, 48'h1234, '1, 8'd1, 0), 0, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_PATH, 0, ones, 0, 0, 0, 0), 0, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_PATH, 0, ones, 0, 0, 0, 1), 0, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_UPDATE, 64'd1, 0, 0, 32'd9, 8'd2, 0), 0, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_PATH, 0, ones, 0, 0, 0, 1), 0, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_PATH, 0, 64'd5, 0, 0, 0, 0), 1, rs(0, 0, 3)});
        rows.push_back('{mk(KIND_INSERT, 64'd1, 64'd7, 48'd77, 32'd3, 0, 0), 0, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_REMOVE, 64'd0, 0, 0, 0, 0, 0), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_REMOVE, 64'd0, 0, 0, 0, 0, 0), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_NOP6, 64'd1, 0, 0, 0, 0, 0), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_NOP7, ones, ones, '1, '1, 8'hff, 1), 1, rs(0, 0, 2)});
        rows.push_back('{mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0)});
        rows.push_back('{mk(KIND_KEY, 64'd1, 0, 0, 0, 0, 0), 1, rs(0, 0, 0)});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].resp);
        drain();

        run_phase(150, 0, 0, 0);
        write_reg(CFG_ACTIVE, 9'd8);
        write_reg(CFG_QUEUED, $urandom_range(255));
        write_reg(CFG_STAGING, $urandom_range(255));
        write_reg(CFG_ONLINE, $urandom_range(255));
        run_phase(250, 66, 0, 0);
        write_reg(CFG_ACTIVE, 9'd1);
        run_phase(150, 0, 66, 0);
        write_reg(CFG_ACTIVE, 9'd0);
        run_phase(60, 24, 24, 0);
        write_reg(CFG_ACTIVE, 9'h1ff);
        run_phase(320, 0, 0, 1);
        write_reg(CFG_ACTIVE, 9'd3);
        write_reg(CFG_QUEUED, 9'd255);
        write_reg(CFG_STAGING, 9'd0);
        write_reg(CFG_ONLINE, 9'd128);
        run_phase(170, 24, 24, 0);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
